// ===== hw/rtl/rsm_pkg.sv =====
`default_nettype none

package rsm_pkg;

    // Stack geometry and datapath width
    localparam int STACK_DEPTH = 64;
    localparam int DATA_WIDTH  = 32;

    // Port widths fixed by the item format
    localparam int IO_W  = 32;
    localparam int OP_W  = 3;
    localparam int ST_W  = 2;

    // Depth counter holds 0..STACK_DEPTH
    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);

    // Divider step counter covers 0..DATA_WIDTH-1
    localparam int DIV_CNT_W = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

    typedef logic [DATA_WIDTH-1:0] t_data;
    typedef logic [DEPTH_W-1:0]    t_depth;

    // Opcodes; 6 and 7 are no-ops
    localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd4;
    localparam logic [OP_W-1:0] OP_REM  = 3'd5;

    typedef enum logic [ST_W-1:0] {
        ST_OK,
        ST_UNDERFLOW,
        ST_DIVZERO,
        ST_FULL
    } t_status;

    // Shift command for the row of stack cells
    typedef struct packed {
        logic push;   // shift toward the bottom, new value enters cell 0
        logic pop;    // shift toward the top, cell 0 takes the op result
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== hw/rtl/rsm_cell.sv =====
`default_nettype none

// One stack entry. Takes its upper neighbor on push, its lower neighbor
// on pop, holds otherwise.
module rsm_cell (
    input  wire                  i_clk,
    input  rsm_pkg::t_cell_ctl   i_ctl,
    input  rsm_pkg::t_data       i_from_above,
    input  rsm_pkg::t_data       i_from_below,
    output rsm_pkg::t_data       o_value
);

    rsm_pkg::t_data r_value;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_value <= i_from_above;
        end else if (i_ctl.pop) begin
            r_value <= i_from_below;
        end
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

// ===== hw/rtl/rsm_divider.sv =====
`default_nettype none

// Radix-2 restoring divider on unsigned magnitudes, one quotient bit
// per cycle. o_done pulses for one cycle once results are valid.
module rsm_divider (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    input  rsm_pkg::t_data       i_dividend,
    input  rsm_pkg::t_data       i_divisor,
    output logic                 o_done,
    output rsm_pkg::t_data       o_quotient,
    output rsm_pkg::t_data       o_remainder
);

    localparam int W = rsm_pkg::DATA_WIDTH;
    localparam logic [rsm_pkg::DIV_CNT_W-1:0] LAST_STEP =
        rsm_pkg::DIV_CNT_W'(W - 1);

    logic                           r_run;
    logic                           r_done;
    logic [rsm_pkg::DIV_CNT_W-1:0]  r_cnt;
    rsm_pkg::t_data                 r_quo;
    rsm_pkg::t_data                 r_rem;
    rsm_pkg::t_data                 r_dvs;

    logic [W+1:0]                   n_trial;

    // partial remainder shifted by one bit, minus divisor; MSB is the borrow
    assign n_trial = {1'b0, r_rem, r_quo[W-1]} - {2'b00, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
                r_quo <= i_dividend;
                r_rem <= '0;
                r_dvs <= i_divisor;
            end else if (r_run) begin
                if (n_trial[W+1]) begin
                    r_rem <= {r_rem[W-2:0], r_quo[W-1]};
                    r_quo <= {r_quo[W-2:0], 1'b0};
                end else begin
                    r_rem <= n_trial[W-1:0];
                    r_quo <= {r_quo[W-2:0], 1'b1};
                end
                r_cnt <= r_cnt + rsm_pkg::DIV_CNT_W'(1);
                if (r_cnt == LAST_STEP) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

// ===== hw/rtl/rpn_stack_machine_core.sv =====
`default_nettype none

// Channel   Direction  Handshake              Payload
// command   in         start & !busy          i_operation, i_push_value
// result    out        o_strobe (one cycle)   o_top_value, o_depth, o_status
//
// Push, add, subtract, no-op and all error cases complete on acceptance; busy stays low.
// Multiply: the low product word is registered, then written back from S_MUL.
// Divide, remainder: the core waits in S_DIV on the
// radix-2 divider loop that produces one quotient bit per cycle.
// o_strobe is high for the cycle after an item completes; the receiver cannot stall.
// Sync active-low reset empties the stack (depth 0); cell contents are not reset.
module rpn_stack_machine_core (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                start,
    input  wire  [rsm_pkg::OP_W-1:0]           i_operation,
    input  wire  signed [rsm_pkg::IO_W-1:0]    i_push_value,
    output logic                               busy,
    output logic                               o_strobe,
    output logic signed [rsm_pkg::IO_W-1:0]    o_top_value,
    output logic [rsm_pkg::DEPTH_W-1:0]        o_depth,
    output logic [rsm_pkg::ST_W-1:0]           o_status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV
    } t_state;

    // two's complement negate at data width
    function automatic rsm_pkg::t_data neg_w(input rsm_pkg::t_data v);
        return ~v + rsm_pkg::t_data'(1);
    endfunction

    function automatic rsm_pkg::t_data mag_w(input rsm_pkg::t_data v);
        return v[rsm_pkg::DATA_WIDTH-1] ? neg_w(v) : v;
    endfunction

    // push value: sign-extend or truncate from port width to data width
    function automatic rsm_pkg::t_data push_ext(
        input logic signed [rsm_pkg::IO_W-1:0] v
    );
        return rsm_pkg::t_data'(v);
    endfunction

    // ---------------- registers ----------------
    t_state                 r_state, n_state;
    rsm_pkg::t_depth        r_depth, n_depth;
    logic                   r_strobe;
    rsm_pkg::t_data         r_top,   n_top;
    rsm_pkg::t_status       r_status, n_status;
    logic [rsm_pkg::OP_W-1:0] r_op,  n_op;
    rsm_pkg::t_data         r_prod,  n_prod;
    logic                   r_neg_q, n_neg_q;   // quotient sign
    logic                   r_neg_r, n_neg_r;   // remainder sign

    // ---------------- datapath wires ----------------
    rsm_pkg::t_data         cell_val [rsm_pkg::STACK_DEPTH];
    rsm_pkg::t_cell_ctl     cell_ctl;
    rsm_pkg::t_data         n_result;   // value written into cell 0 on pop
    logic                   commit;
    logic                   accept;
    logic                   div_start;
    logic                   div_done;
    rsm_pkg::t_data         div_quo;
    rsm_pkg::t_data         div_rem;
    rsm_pkg::t_data         op_a;       // second from top: left operand
    rsm_pkg::t_data         op_b;       // top: right operand
    rsm_pkg::t_data         mul_lo;
    logic                   is_empty;
    logic                   is_full;
    logic                   too_few;

    assign accept   = start && (r_state == S_IDLE);
    assign op_b     = cell_val[0];
    assign op_a     = cell_val[1];
    assign mul_lo   = rsm_pkg::t_data'(op_a * op_b);
    assign is_empty = (r_depth == '0);
    assign is_full  = (r_depth == rsm_pkg::DEPTH_W'(rsm_pkg::STACK_DEPTH));
    assign too_few  = (r_depth < rsm_pkg::DEPTH_W'(2));

    // ---------------- stack: row of shift cells, cell 0 is top ----------------
    for (genvar g = 0; g < rsm_pkg::STACK_DEPTH; g++) begin : g_cell
        rsm_pkg::t_data above;
        rsm_pkg::t_data below;

        if (g == 0) begin : g_top
            assign above = push_ext(i_push_value);
            assign below = n_result;
        end else if (g == rsm_pkg::STACK_DEPTH - 1) begin : g_bottom
            assign above = cell_val[g-1];
            assign below = '0;
        end else begin : g_mid
            assign above = cell_val[g-1];
            assign below = cell_val[g+1];
        end

        rsm_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (cell_ctl),
            .i_from_above (above),
            .i_from_below (below),
            .o_value      (cell_val[g])
        );
    end

    // ---------------- divider on magnitudes ----------------
    rsm_divider u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (mag_w(op_a)),
        .i_divisor   (mag_w(op_b)),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // ---------------- control ----------------
    always_comb begin
        n_state   = r_state;
        n_depth   = r_depth;
        n_status  = rsm_pkg::ST_OK;
        n_top     = is_empty ? '0 : cell_val[0];
        n_op      = r_op;
        n_prod    = r_prod;
        n_neg_q   = r_neg_q;
        n_neg_r   = r_neg_r;
        n_result  = '0;
        cell_ctl  = '0;
        commit    = 1'b0;
        div_start = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op = i_operation;
                    unique case (i_operation)
                        rsm_pkg::OP_PUSH: begin
                            commit = 1'b1;
                            if (is_full) begin
                                n_status = rsm_pkg::ST_FULL;
                            end else begin
                                cell_ctl.push = 1'b1;
                                n_depth       = r_depth + rsm_pkg::DEPTH_W'(1);
                                n_top         = push_ext(i_push_value);
                            end
                        end
                        rsm_pkg::OP_ADD, rsm_pkg::OP_SUB: begin
                            commit = 1'b1;
                            if (too_few) begin
                                n_status = rsm_pkg::ST_UNDERFLOW;
                            end else begin
                                n_result = (i_operation == rsm_pkg::OP_ADD) ?
                                           op_a + op_b : op_a - op_b;
                                cell_ctl.pop = 1'b1;
                                n_depth      = r_depth - rsm_pkg::DEPTH_W'(1);
                                n_top        = n_result;
                            end
                        end
                        rsm_pkg::OP_MUL: begin
                            if (too_few) begin
                                commit   = 1'b1;
                                n_status = rsm_pkg::ST_UNDERFLOW;
                            end else begin
                                n_prod  = mul_lo;
                                n_state = S_MUL;
                            end
                        end
                        rsm_pkg::OP_DIV, rsm_pkg::OP_REM: begin
                            if (too_few) begin
                                commit   = 1'b1;
                                n_status = rsm_pkg::ST_UNDERFLOW;
                            end else if (op_b == '0) begin
                                commit   = 1'b1;
                                n_status = rsm_pkg::ST_DIVZERO;
                            end else begin
                                div_start = 1'b1;
                                n_neg_q   = op_a[rsm_pkg::DATA_WIDTH-1] ^
                                            op_b[rsm_pkg::DATA_WIDTH-1];
                                n_neg_r   = op_a[rsm_pkg::DATA_WIDTH-1];
                                n_state   = S_DIV;
                            end
                        end
                        default: begin
                            // unused opcodes: no-op, status ok
                            commit = 1'b1;
                        end
                    endcase
                end
            end
            S_MUL: begin
                commit       = 1'b1;
                n_result     = r_prod;
                cell_ctl.pop = 1'b1;
                n_depth      = r_depth - rsm_pkg::DEPTH_W'(1);
                n_top        = n_result;
                n_state      = S_IDLE;
            end
            S_DIV: begin
                if (div_done) begin
                    commit = 1'b1;
                    if (r_op == rsm_pkg::OP_DIV) begin
                        n_result = r_neg_q ? neg_w(div_quo) : div_quo;
                    end else begin
                        n_result = r_neg_r ? neg_w(div_rem) : div_rem;
                    end
                    cell_ctl.pop = 1'b1;
                    n_depth      = r_depth - rsm_pkg::DEPTH_W'(1);
                    n_top        = n_result;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state, depth and registered result outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_depth  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_depth  <= n_depth;
            r_strobe <= commit;
            r_op     <= n_op;
            r_prod   <= n_prod;
            r_neg_q  <= n_neg_q;
            r_neg_r  <= n_neg_r;
            if (commit) begin
                r_top    <= n_top;
                r_status <= n_status;
            end
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_strobe    = r_strobe;
    assign o_top_value = rsm_pkg::IO_W'(r_top);
    assign o_depth     = r_depth;
    assign o_status    = r_status;

`ifndef SYNTHESIS
    // a result is only posted once the long operations have finished
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while busy");

    // depth stays within the stack
    a_depth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= rsm_pkg::DEPTH_W'(rsm_pkg::STACK_DEPTH))
        else $error("stack depth out of range");

    // divider completes only while its result is awaited
    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider done outside divide state");

    // full status only reported with the stack full
    a_full_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status == rsm_pkg::ST_FULL)) |->
            (o_depth == rsm_pkg::DEPTH_W'(rsm_pkg::STACK_DEPTH)))
        else $error("full status with stack not full");
`endif

endmodule

`default_nettype wire
